### rtl/core/first_fit_heap_allocator_top_defines.svh
// Assertion macros for the heap allocator.
// No dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FFHA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/core/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;
  localparam int unsigned MaxBlocks       = 64;
  localparam int unsigned HeaderBytes     = 16;
  localparam int unsigned AlignBytes      = 4;
  localparam int unsigned MinSplitPayload = 16;
  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam logic [31:0] HeapSizeRst     = 32'd1048576;

  localparam logic [1:0] OpAlloc  = 2'd0;
  localparam logic [1:0] OpFree   = 2'd1;
  localparam logic [1:0] OpReinit = 2'd2;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StBadAddr = 2'd2;

  localparam logic CfgHeapBase = 1'b0;
  localparam logic CfgHeapSize = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] request_size;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [31:0] free_bytes;
  } rsp_t;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdInit, CmdRead, CmdEval, CmdShUpRd, CmdShUpWr, CmdSplit,
    CmdGrant, CmdMark, CmdShDnRd, CmdShDnWr, CmdMerge, CmdSumRd, CmdSumAcc
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [IdxW-1:0] idx;
  } ctl_t;

  typedef struct packed {
    logic        hit;     // Eval: alloc fits / free address matches
    logic        split;   // Eval: alloc splits
    logic        pair;    // Read during merge: idx and idx+1 both free
    logic [CntW-1:0] count;
  } sts_t;
endpackage

### rtl/core/ffha_datapath.sv
// Block table storage and arithmetic for the heap allocator.
// Depends on ffha_pkg.
module ffha_datapath import ffha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  input  req_t        req_i,
  input  logic [31:0] heap_base_i,
  input  logic [31:0] heap_size_i,
  output sts_t        sts_o,
  output logic [31:0] address_o,
  output logic [31:0] free_o
);
  logic [31:0] off_mem [MaxBlocks];
  logic [31:0] pay_mem [MaxBlocks];
  logic        free_mem [MaxBlocks];
  logic [CntW-1:0] count_q;
  logic [31:0] rd_off_q, rd_pay_q, hold_off_q, hold_pay_q, addr_q, nxt_pay_q;
  logic        rd_free_q, hold_free_q, init_q;
  logic [32:0] want_q;
  logic [33:0] sum_q;
  logic [31:0] free_total_q;
  logic [1:0]  op_q;
  logic [31:0] rel_q;
  logic        hit_q, split_q, pair_q;
  logic [IdxW-1:0] wr_idx;
  logic [31:0] wr_off, wr_pay, init_pay;
  logic        wr_en, wr_free;
  logic [IdxW-1:0] rd_idx;
  logic [31:0] paddr;
  logic [33:0] split_need;

  assign paddr = heap_base_i + rd_off_q + 32'(HeaderBytes);
  assign split_need = {1'b0, want_q} + 34'(HeaderBytes + MinSplitPayload);
  assign init_pay = (heap_size_i >= 32'(HeaderBytes)) ? heap_size_i - 32'(HeaderBytes) : '0;

  always_comb begin
    rd_idx = ctl_i.idx;
    wr_en = 1'b0; wr_idx = ctl_i.idx; wr_off = rd_off_q; wr_pay = rd_pay_q;
    wr_free = rd_free_q;
    case (ctl_i.cmd)
      CmdInit: begin
        wr_en = 1'b1; wr_idx = '0; wr_off = '0; wr_pay = init_pay; wr_free = 1'b1;
      end
      CmdShUpRd: rd_idx = ctl_i.idx - IdxW'(1);
      CmdShDnRd: rd_idx = ctl_i.idx + IdxW'(1);
      // prefetch the next entry while accumulating this one
      CmdSumAcc: rd_idx = ctl_i.idx + IdxW'(1);
      CmdShUpWr, CmdShDnWr: wr_en = 1'b1;
      CmdSplit: begin
        wr_en = 1'b1; wr_idx = ctl_i.idx + IdxW'(1);
        wr_off = hold_off_q + 32'(HeaderBytes) + want_q[31:0];
        wr_pay = hold_pay_q - want_q[31:0] - 32'(HeaderBytes);
        wr_free = 1'b1;
      end
      CmdGrant: begin
        wr_en = 1'b1; wr_off = hold_off_q;
        wr_pay = split_q ? want_q[31:0] : hold_pay_q;
        wr_free = 1'b0;
      end
      CmdMark: begin
        wr_en = 1'b1; wr_off = hold_off_q; wr_pay = hold_pay_q; wr_free = 1'b1;
      end
      CmdMerge: begin
        wr_en = 1'b1; wr_off = hold_off_q; wr_pay = nxt_pay_q; wr_free = 1'b1;
      end
      default: ;
    endcase
    // first cycle out of reset: entry zero spans the region
    if (init_q) begin
      wr_en = 1'b1; wr_idx = '0; wr_off = '0; wr_pay = init_pay; wr_free = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      off_mem[wr_idx] <= wr_off;
      pay_mem[wr_idx] <= wr_pay;
      free_mem[wr_idx] <= wr_free;
    end
    rd_off_q <= off_mem[rd_idx];
    rd_pay_q <= pay_mem[rd_idx];
    rd_free_q <= free_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1; count_q <= CntW'(1);
      free_total_q <= HeapSizeRst - 32'(HeaderBytes);
      hit_q <= 1'b0; split_q <= 1'b0; pair_q <= 1'b0;
      sum_q <= '0; addr_q <= '0; op_q <= '0; rel_q <= '0; want_q <= '0;
      hold_off_q <= '0; hold_pay_q <= '0; hold_free_q <= 1'b0; nxt_pay_q <= '0;
    end else begin
      init_q <= 1'b0;
      case (ctl_i.cmd)
        CmdLoad: begin
          op_q <= req_i.op; rel_q <= req_i.release_address; addr_q <= '0;
          want_q <= ({1'b0, req_i.request_size} + 33'(AlignBytes - 1)) &
                    ~33'(AlignBytes - 1);
          hit_q <= 1'b0; pair_q <= 1'b0;
        end
        CmdInit: begin
          count_q <= CntW'(1); addr_q <= '0;
        end
        CmdEval: begin
          hold_off_q <= rd_off_q; hold_pay_q <= rd_pay_q; hold_free_q <= rd_free_q;
          if (op_q == OpAlloc) begin
            hit_q <= rd_free_q && ({1'b0, rd_pay_q} >= want_q);
            split_q <= ({2'b0, rd_pay_q} >= split_need) && (count_q < CntW'(MaxBlocks));
          end else if (op_q == OpFree) begin
            hit_q <= (paddr == rel_q) && (rel_q != '0);
          end
        end
        CmdSplit: count_q <= count_q + CntW'(1);
        CmdGrant: addr_q <= heap_base_i + hold_off_q + 32'(HeaderBytes);
        CmdRead: begin
          // merge check of idx and idx+1 uses both entries' free flags
          pair_q <= hold_free_q && rd_free_q;
          // merged payload, saturated; rd_pay_q holds entry idx+1 here
          nxt_pay_q <= ({2'b0, hold_pay_q} + 34'(HeaderBytes) + {2'b0, rd_pay_q} > 34'hFFFFFFFF)
                       ? 32'hFFFFFFFF : hold_pay_q + 32'(HeaderBytes) + rd_pay_q;
        end
        CmdMerge: count_q <= count_q - CntW'(1);
        CmdSumRd: sum_q <= '0;
        CmdSumAcc: begin
          if (rd_free_q) sum_q <= sum_q + {2'b0, rd_pay_q};
          free_total_q <= sum_q[31:0] + (rd_free_q ? rd_pay_q : 32'd0);
        end
        default: ;
      endcase
    end
  end

  assign sts_o = '{hit: hit_q, split: split_q, pair: pair_q, count: count_q};
  assign address_o = addr_q;
  assign free_o = free_total_q;
endmodule

### rtl/core/ffha_ctrl.sv
// Sequencer for the heap allocator: walks, shifts and sums the block table.
// Depends on ffha_pkg.
module ffha_ctrl import ffha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  status_o,
  input  sts_t        sts_i,
  output ctl_t        ctl_o
);
  typedef enum logic [13:0] {
    SIdle  = 14'b00000000000001, SARd  = 14'b00000000000010,
    SAEv   = 14'b00000000000100, SAChk = 14'b00000000001000,
    SUpRd  = 14'b00000000010000, SUpWr = 14'b00000000100000,
    SGrant = 14'b00000001000000, SFRd  = 14'b00000010000000,
    SFEv   = 14'b00000100000000, SMRd  = 14'b00001000000000,
    SMEv   = 14'b00010000000000, SDn   = 14'b00100000000000,
    SSum   = 14'b01000000000000, SOut  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [1:0] st_q, st_d;
  logic       sum_lag_q, sum_lag_d;
  logic [1:0] mph_q, mph_d;

  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; st_d = st_q;
    sum_lag_d = sum_lag_q; mph_d = mph_q;
    ctl_o = '{cmd: CmdNone, idx: i_q[IdxW-1:0]};
    case (state_q)
      SIdle: if (in_valid_i) begin
        ctl_o.cmd = CmdLoad; i_d = '0; st_d = StDone;
        case (op_i)
          OpAlloc: state_d = SARd;
          OpFree:  state_d = SFRd;
          OpReinit: begin state_d = SSum; ctl_o.cmd = CmdInit; end
          default: state_d = SSum;
        endcase
        sum_lag_d = 1'b0; mph_d = '0;
      end
      SARd: begin
        if (i_q >= sts_i.count) begin st_d = StNoSpace; state_d = SSum; i_d = '0; end
        else state_d = SAEv;
      end
      SAEv: begin ctl_o.cmd = CmdEval; state_d = SAChk; end
      SAChk: begin
        if (sts_i.hit) begin
          if (sts_i.split) begin j_d = sts_i.count; state_d = SUpRd; end
          else state_d = SGrant;
        end else begin i_d = i_q + CntW'(1); state_d = SARd; end
      end
      SUpRd: begin
        if (j_q > i_q + CntW'(1)) begin
          ctl_o = '{cmd: CmdShUpRd, idx: j_q[IdxW-1:0]}; state_d = SUpWr;
        end else begin
          ctl_o.cmd = CmdSplit; state_d = SGrant;
        end
      end
      SUpWr: begin
        ctl_o = '{cmd: CmdShUpWr, idx: j_q[IdxW-1:0]};
        j_d = j_q - CntW'(1); state_d = SUpRd;
      end
      SGrant: begin ctl_o.cmd = CmdGrant; i_d = '0; state_d = SSum; end
      SFRd: begin
        if (i_q >= sts_i.count) begin st_d = StBadAddr; i_d = '0; state_d = SSum; end
        else state_d = SFEv;
      end
      SFEv: begin
        if (mph_q == 2'd0) begin ctl_o.cmd = CmdEval; mph_d = 2'd1; end
        else begin
          mph_d = 2'd0;
          if (sts_i.hit) begin ctl_o.cmd = CmdMark; i_d = '0; state_d = SMRd; end
          else begin i_d = i_q + CntW'(1); state_d = SFRd; end
        end
      end
      // merge pass: read idx (hold), then idx+1 (payload), check pair
      SMRd: begin
        if (i_q + CntW'(1) >= sts_i.count) begin i_d = '0; state_d = SSum; end
        else state_d = SMEv;
        mph_d = '0;
      end
      SMEv: begin
        case (mph_q)
          2'd0: begin ctl_o.cmd = CmdEval; mph_d = 2'd1; end
          2'd1: begin
            ctl_o = '{cmd: CmdEval, idx: i_q[IdxW-1:0] + IdxW'(1)}; mph_d = 2'd2;
          end
          2'd2: begin
            ctl_o = '{cmd: CmdNone, idx: i_q[IdxW-1:0] + IdxW'(1)};
            mph_d = 2'd3;
          end
          default: begin
            ctl_o.cmd = CmdRead; mph_d = '0; state_d = SDn;
            j_d = i_q;
          end
        endcase
      end
      SDn: begin
        if (mph_q == 2'd0) begin
          mph_d = 2'd1;
          if (!sts_i.pair) begin i_d = i_q + CntW'(1); state_d = SMRd; mph_d = '0; end
          else begin
            ctl_o.cmd = CmdMerge; j_d = i_q + CntW'(1);
          end
        end else if (mph_q == 2'd1) begin
          if (j_q + CntW'(1) < sts_i.count + CntW'(1)) begin
            ctl_o = '{cmd: CmdShDnRd, idx: j_q[IdxW-1:0]}; mph_d = 2'd2;
          end else begin mph_d = '0; state_d = SMRd; end
        end else begin
          ctl_o = '{cmd: CmdShDnWr, idx: j_q[IdxW-1:0]};
          j_d = j_q + CntW'(1); mph_d = 2'd1;
        end
      end
      SSum: begin
        if (!sum_lag_q) begin
          ctl_o = '{cmd: CmdSumRd, idx: '0}; sum_lag_d = 1'b1; i_d = '0;
        end else begin
          ctl_o = '{cmd: CmdSumAcc, idx: i_q[IdxW-1:0]};
          if (i_q + CntW'(1) >= sts_i.count) state_d = SOut;
          else i_d = i_q + CntW'(1);
        end
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; i_q <= '0; j_q <= '0; st_q <= StDone;
      sum_lag_q <= 1'b0; mph_q <= '0;
    end else begin
      state_q <= state_d; i_q <= i_d; j_q <= j_d; st_q <= st_d;
      sum_lag_q <= sum_lag_d; mph_q <= mph_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign status_o    = st_q;
endmodule

### rtl/core/first_fit_heap_allocator_top.sv
// First-fit heap allocator over an address-ordered table of up to 64 blocks. One
// transaction is handled at a time: an allocate walks the table and shifts entries
// up on a split; a free searches the table, then merges free neighbour pairs and
// shifts entries down; every op ends with a sum of free payloads at one entry per
// cycle. All walks go through the table memory, which has one read and one write
// port. heap_size applies at reset or reinitialize.
`include "first_fit_heap_allocator_top_defines.svh"
module first_fit_heap_allocator_top import ffha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [31:0] heap_base_q, heap_size_q;
  ctl_t ctl;
  sts_t sts;
  logic [1:0] status;
  logic [31:0] addr, free_b;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0; heap_size_q <= HeapSizeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHeapBase: heap_base_q <= cfg_data_i;
        CfgHeapSize: heap_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i(in_data_i.op),
    .out_ready_i, .out_valid_o, .status_o(status), .sts_i(sts), .ctl_o(ctl)
  );

  ffha_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .req_i(in_data_i), .heap_base_i(heap_base_q),
    .heap_size_i(heap_size_q), .sts_o(sts), .address_o(addr), .free_o(free_b)
  );

  assign out_data_o = '{status: status, address: addr, free_bytes: free_b};

  `FFHA_ASSERT_IMP(a_excl, out_valid_o, !in_ready_o)
  `FFHA_ASSERT_IMP(a_cnt, 1'b1, sts.count != '0)
  `FFHA_ASSERT_IMP(a_addr, out_valid_o && status != StDone, addr == '0)
endmodule

### tb/sv/testbench.sv
// Self-checking bench for first_fit_heap_allocator_top: directed table, then random traffic
// over several heap settings, checked against an in-bench model of the block table.
// Depends on ffha_pkg and the RTL of first_fit_heap_allocator_top.
module testbench;
  import ffha_pkg::*;

  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ItemsPerPhase = 250;

  typedef struct packed {
    req_t item;
    logic typed;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CfgHeapBase;
  logic [31:0] cfg_data = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned err_cnt = 0;

  rsp_t rsp_q[$];
  logic [31:0] live_q[$];
  logic [31:0] last_freed = '0;

  // heap bookkeeping mirror
  logic [31:0] heap_base_m, heap_size_m;
  logic [31:0] blk_off[MaxBlocks];
  logic [31:0] blk_pay[MaxBlocks];
  bit blk_free[MaxBlocks];
  int unsigned blk_cnt;

  always #5 clk = ~clk;

  first_fit_heap_allocator_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic void heap_restore();
    for (int i = 0; i < MaxBlocks; i++) begin
      blk_off[i] = '0;
      blk_pay[i] = '0;
      blk_free[i] = 1'b0;
    end
    blk_pay[0] = (heap_size_m >= HeaderBytes) ? heap_size_m - HeaderBytes : 32'd0;
    blk_free[0] = 1'b1;
    blk_cnt = 1;
  endfunction

  function automatic logic [31:0] payload_addr(int unsigned idx);
    return heap_base_m + blk_off[idx] + HeaderBytes;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned j = idx; j + 1 < blk_cnt; j++) begin
      blk_off[j] = blk_off[j+1];
      blk_pay[j] = blk_pay[j+1];
      blk_free[j] = blk_free[j+1];
    end
    blk_cnt--;
  endfunction

  function automatic rsp_t heap_alloc(logic [31:0] req);
    rsp_t r;
    longint unsigned want;
    logic [63:0] nxt;
    want = ((longint'(req) + AlignBytes - 1) / AlignBytes) * AlignBytes;
    r = '0;
    r.status = StNoSpace;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (!blk_free[i] || longint'(blk_pay[i]) < want) continue;
      if (longint'(blk_pay[i]) >= want + HeaderBytes + MinSplitPayload &&
          blk_cnt < MaxBlocks) begin
        for (int unsigned j = blk_cnt; j > i + 1; j--) begin
          blk_off[j] = blk_off[j-1];
          blk_pay[j] = blk_pay[j-1];
          blk_free[j] = blk_free[j-1];
        end
        nxt = longint'(blk_off[i]) + HeaderBytes + want;
        blk_off[i+1] = nxt[31:0];
        nxt = longint'(blk_pay[i]) - want - HeaderBytes;
        blk_pay[i+1] = nxt[31:0];
        blk_free[i+1] = 1'b1;
        blk_pay[i] = want[31:0];
        blk_cnt++;
      end
      blk_free[i] = 1'b0;
      r.status = StDone;
      r.address = payload_addr(i);
      return r;
    end
    return r;
  endfunction

  function automatic logic [1:0] heap_release(logic [31:0] rel);
    int unsigned i;
    bit found;
    longint unsigned merged;
    found = 1'b0;
    if (rel == '0) return StBadAddr;
    for (i = 0; i < blk_cnt; i++) begin
      if (payload_addr(i) == rel) begin
        blk_free[i] = 1'b1;
        found = 1'b1;
        break;
      end
    end
    if (!found) return StBadAddr;
    i = 0;
    while (i + 1 < blk_cnt) begin
      if (blk_free[i] && blk_free[i+1]) begin
        merged = longint'(blk_pay[i]) + HeaderBytes + blk_pay[i+1];
        blk_pay[i] = (merged > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : merged[31:0];
        drop_entry(i + 1);
      end else begin
        i++;
      end
    end
    return StDone;
  endfunction

  function automatic rsp_t heap_step(req_t q);
    rsp_t r;
    logic [63:0] sum;
    r = '0;
    case (q.op)
      OpAlloc: r = heap_alloc(q.request_size);
      OpFree: r.status = heap_release(q.release_address);
      OpReinit: heap_restore();
      default: ;
    endcase
    sum = '0;
    for (int unsigned i = 0; i < blk_cnt; i++)
      if (blk_free[i]) sum += blk_pay[i];
    r.free_bytes = sum[31:0];
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_item(req_t q, logic typed = 1'b0, rsp_t want_rsp = '0);
    rsp_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (!in_ready);
    p = heap_step(q);
    if (q.op == OpAlloc && p.status == StDone) live_q.push_back(p.address);
    if (q.op == OpReinit) live_q.delete();
    rsp_q.push_back(typed ? want_rsp : p);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    while (rsp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgHeapBase) heap_base_m = val;
    else heap_size_m = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t rand_item();
    req_t q;
    int unsigned k, s;
    q.op = OpAlloc;
    q.request_size = $urandom;
    q.release_address = $urandom;
    k = $urandom_range(99);
    if (k < 50 || k >= 90) begin
      s = $urandom_range(9);
      if (s < 7) q.request_size = $urandom_range(64);
      else if (s == 7) q.request_size = $urandom_range(4096);
      else if (s == 9) q.request_size = '0;
    end else if (k < 85) begin
      q.op = OpFree;
      s = $urandom_range(9);
      if (live_q.size() != 0 && s < 8) begin
        s = $urandom_range(live_q.size() - 1);
        q.release_address = live_q[s];
        live_q.delete(s);
        last_freed = q.release_address;
      end else if (s == 8) begin
        q.release_address = last_freed;  // double free
      end else if ($urandom_range(1) == 0) begin
        q.release_address = '0;
      end
    end else if (k < 88) begin
      q.op = OpReinit;
    end else begin
      q.op = OpNone;
    end
    return q;
  endfunction

  // receiver: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (rsp_q.size() == 0) begin
        $error("result with nothing pending: %h", out_data);
        err_cnt++;
      end else begin
        e = rsp_q.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          err_cnt++;
        end
        if (out_data.address !== e.address) begin
          $error("address: expected %h, got %h", e.address, out_data.address);
          err_cnt++;
        end
        if (out_data.free_bytes !== e.free_bytes) begin
          $error("free_bytes: expected %0d, got %0d", e.free_bytes, out_data.free_bytes);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [31:0] bases[NumPhases];
    logic [31:0] sizes[NumPhases];
    req_t q;
    rows = '{
      '{'{OpFree, 32'd0, 32'd0}, 1'b1, '{StBadAddr, 32'd0, 32'd1048560}},
      '{'{OpFree, 32'hFFFF_FFFF, 32'h1234_5678}, 1'b1, '{StBadAddr, 32'd0, 32'd1048560}},
      '{'{OpAlloc, 32'hFFFF_FFFF, 32'd0}, 1'b1, '{StNoSpace, 32'd0, 32'd1048560}},
      '{'{OpNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{StDone, 32'd0, 32'd1048560}},
      '{'{OpAlloc, 32'd0, 32'd0}, 1'b1, '{StDone, 32'd16, 32'd1048544}},
      '{'{OpFree, 32'd0, 32'd16}, 1'b1, '{StDone, 32'd0, 32'd1048560}},
      '{'{OpFree, 32'd0, 32'd16}, 1'b1, '{StDone, 32'd0, 32'd1048560}},
      '{'{OpAlloc, 32'd1, 32'd0}, 1'b0, '0},
      '{'{OpAlloc, 32'd3, 32'd0}, 1'b0, '0},
      '{'{OpAlloc, 32'd5, 32'd0}, 1'b0, '0},
      '{'{OpFree, 32'd0, 32'd36}, 1'b0, '0},
      '{'{OpFree, 32'd0, 32'd16}, 1'b0, '0},
      '{'{OpFree, 32'd0, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{OpAlloc, 32'h7FFF_FFFF, 32'd0}, 1'b0, '0},
      '{'{OpAlloc, 32'd1048561, 32'd0}, 1'b0, '0},
      '{'{OpAlloc, 32'd1048560, 32'd0}, 1'b0, '0},
      '{'{OpAlloc, 32'd0, 32'd0}, 1'b0, '0},
      '{'{OpReinit, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{StDone, 32'd0, 32'd1048560}},
      '{'{OpAlloc, 32'd1048528, 32'd0}, 1'b0, '0},
      '{'{OpAlloc, 32'd1048529, 32'd0}, 1'b0, '0},
      '{'{OpReinit, 32'd0, 32'd0}, 1'b1, '{StDone, 32'd0, 32'd1048560}}
    };
    bases = '{32'h0, 32'h1000, 32'hFFFF_FFF0, 32'h1234_5678, 32'h8000_0000, 32'h0};
    sizes = '{32'd1048576, 32'd4096, 32'd64, 32'hFFFF_FFFF, 32'd8, 32'd2048};
    heap_base_m = '0;
    heap_size_m = 32'd1048576;
    heap_restore();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].rsp);

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      in_valid <= 1'b0;
      write_reg(CfgHeapBase, bases[p]);
      write_reg(CfgHeapSize, sizes[p]);
      q = '0;
      q.op = OpReinit;
      send_item(q);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 1 && n == 20) begin
          @(posedge clk);
          hold_req = 1'b1;
          @(negedge clk);
        end
        send_item(rand_item());
      end
    end
    in_valid <= 1'b0;
    while (rsp_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
